// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants for the serial frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

    // fixed frame bytes
    localparam logic [7:0] FOOTER_BYTE        = 8'h5A;
    localparam logic [7:0] HEADER_FIRST_RST   = 8'hFC;
    localparam logic [7:0] HEADER_SECOND_RST  = 8'hC5;
    localparam logic [7:0] LENGTH_CODE_RST    = 8'h52;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_LENGTH_CODE   = 2'd2
    } t_cfg_idx;

    // receive phase
    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CSUM    = 3'd4,
        PH_FOOTER  = 3'd5
    } t_phase;

    // result status codes
    typedef enum logic [2:0] {
        ST_HUNT       = 3'd0,
        ST_IN_FRAME   = 3'd1,
        ST_GOOD       = 3'd2,
        ST_CSUM_BAD   = 3'd3,
        ST_FOOTER_BAD = 3'd4,
        ST_READ       = 3'd5
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic       frame_ready;
        logic [7:0] read_byte;
        logic [7:0] byte_position;
    } t_res;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] length_code;
    } t_cfg;

    // frame store access from the deframer
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } t_mem_req;

    // per-beat outcome, before the read data is merged
    typedef struct packed {
        t_status    status;
        logic       frame_ready;
        logic       rd_ok;
        logic [7:0] byte_position;
    } t_step;

endpackage

// ===== rtl/sfr_frame_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_frame_store
// frame byte buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module sfr_frame_store #(
    parameter int FRAME_BYTES = 88
) (
    input  logic             i_clk,
    input  sfr_pkg::t_mem_req i_req,
    output logic [7:0]       o_rd_data
);

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    logic [7:0] r_mem [FRAME_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sfr_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_deframer
// header hunt, position tracking, checksum sum and ready flag
// ----------------------------------------------------------------------------
module sfr_deframer #(
    parameter int FRAME_BYTES = 88
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  sfr_pkg::t_item    i_item,
    input  sfr_pkg::t_cfg     i_cfg,
    output sfr_pkg::t_step    o_step,
    output sfr_pkg::t_mem_req o_mem_req
);

    localparam logic [7:0] CSUM_START = 8'(FRAME_BYTES - 3);
    localparam logic [7:0] FOOTER_POS = 8'(FRAME_BYTES - 1);
    localparam logic [8:0] DEPTH      = 9'(FRAME_BYTES);

    sfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_pos, n_pos;
    logic [15:0]     r_sum, n_sum;
    logic            r_ready, n_ready;
    logic [7:0]      r_csum_lo, n_csum_lo;
    logic [7:0]      r_csum_hi, n_csum_hi;

    logic [7:0] rx;
    logic [7:0] pos_inc;
    logic [7:0] want;
    logic       hdr_match;
    logic       csum_match;
    logic       rx_beat;

    assign rx         = i_item.rx_byte;
    assign pos_inc    = r_pos + 8'd1;
    assign csum_match = ({r_csum_hi, r_csum_lo} == r_sum);
    assign rx_beat    = i_en && !i_item.mode;
    assign hdr_match  = (rx == want);

    always_comb begin
        case (r_phase)
            sfr_pkg::PH_HDR1: want = i_cfg.header_first;
            sfr_pkg::PH_HDR2: want = i_cfg.header_second;
            default:          want = i_cfg.length_code;
        endcase
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_ready   = r_ready;
        n_csum_lo = r_csum_lo;
        n_csum_hi = r_csum_hi;
        if (rx_beat) begin
            case (r_phase)
                sfr_pkg::PH_HDR1, sfr_pkg::PH_HDR2, sfr_pkg::PH_LEN: begin
                    if (hdr_match) begin
                        n_pos = pos_inc;
                        case (r_phase)
                            sfr_pkg::PH_HDR1: n_phase = sfr_pkg::PH_HDR2;
                            sfr_pkg::PH_HDR2: n_phase = sfr_pkg::PH_LEN;
                            default: begin
                                n_phase = sfr_pkg::PH_PAYLOAD;
                                n_sum   = r_sum + {8'd0, rx};
                            end
                        endcase
                    end else begin
                        n_phase = sfr_pkg::PH_HDR1;
                        n_pos   = 8'd0;
                    end
                end
                sfr_pkg::PH_PAYLOAD: begin
                    n_sum = r_sum + {8'd0, rx};
                    n_pos = pos_inc;
                    if (pos_inc == CSUM_START) begin
                        n_phase = sfr_pkg::PH_CSUM;
                    end
                end
                sfr_pkg::PH_CSUM: begin
                    n_pos = pos_inc;
                    // low byte first, high byte right before the footer
                    if (r_pos == CSUM_START) begin
                        n_csum_lo = rx;
                    end else begin
                        n_csum_hi = rx;
                    end
                    if (pos_inc == FOOTER_POS) begin
                        n_phase = sfr_pkg::PH_FOOTER;
                    end
                end
                sfr_pkg::PH_FOOTER: begin
                    if (rx == sfr_pkg::FOOTER_BYTE) begin
                        if (csum_match) begin
                            n_ready = 1'b1;
                        end
                    end else begin
                        n_ready = 1'b0;
                    end
                    n_phase = sfr_pkg::PH_HDR1;
                    n_pos   = 8'd0;
                    n_sum   = 16'd0;
                end
                default: begin
                    n_phase = sfr_pkg::PH_HDR1;
                    n_pos   = 8'd0;
                    n_sum   = 16'd0;
                    n_ready = 1'b0;
                end
            endcase
        end
    end

    // outputs for this beat
    always_comb begin
        o_step.status        = sfr_pkg::ST_HUNT;
        o_step.frame_ready   = n_ready;
        o_step.rd_ok         = 1'b0;
        o_step.byte_position = 8'd0;
        o_mem_req.we         = 1'b0;
        o_mem_req.waddr      = r_pos;
        o_mem_req.wdata      = rx;
        o_mem_req.re         = 1'b0;
        o_mem_req.raddr      = i_item.read_index;
        if (i_item.mode) begin
            o_step.status = sfr_pkg::ST_READ;
            o_step.rd_ok  = ({1'b0, i_item.read_index} < DEPTH);
            o_mem_req.re  = i_en && o_step.rd_ok;
        end else begin
            case (r_phase)
                sfr_pkg::PH_HDR1, sfr_pkg::PH_HDR2, sfr_pkg::PH_LEN: begin
                    if (hdr_match) begin
                        o_step.status        = sfr_pkg::ST_IN_FRAME;
                        o_step.byte_position = r_pos;
                        o_mem_req.we         = i_en;
                    end
                end
                sfr_pkg::PH_PAYLOAD, sfr_pkg::PH_CSUM: begin
                    o_step.status        = sfr_pkg::ST_IN_FRAME;
                    o_step.byte_position = r_pos;
                    o_mem_req.we         = i_en;
                end
                sfr_pkg::PH_FOOTER: begin
                    o_step.byte_position = r_pos;
                    o_mem_req.we         = i_en;
                    if (rx != sfr_pkg::FOOTER_BYTE) begin
                        o_step.status = sfr_pkg::ST_FOOTER_BAD;
                    end else if (csum_match) begin
                        o_step.status = sfr_pkg::ST_GOOD;
                    end else begin
                        o_step.status = sfr_pkg::ST_CSUM_BAD;
                    end
                end
                default: o_step.status = sfr_pkg::ST_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfr_pkg::PH_HDR1;
            r_pos   <= 8'd0;
            r_sum   <= 16'd0;
            r_ready <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_ready <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_csum_lo <= n_csum_lo;
        r_csum_hi <= n_csum_hi;
    end

endmodule

// ===== rtl/serial_frame_receiver_checksum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_checksum
// byte-wise frame deframer with additive checksum and frame buffer read-back
// ----------------------------------------------------------------------------
// usage
//   input beats (i_valid / o_stall) carry either a received serial byte
//   (mode 0) or a read request for the frame buffer (mode 1)
//   result beats (o_valid / i_stall) carry one status word per input beat,
//   in order
//   a beat is taken when valid is high and stall is low
//   the deframer state, the frame buffer read port and stage a update at the
//   accepting edge; the result register loads from stage a once it is empty
//   or the receiver takes the beat it holds
//   throughput is one beat per cycle while the receiver does not stall, set
//   by the deframer update and the one write, one read buffer
//   when the receiver stalls, the result register and the stage behind it
//   fill, and o_stall rises only once both hold a beat
//   reset returns to header hunting, clears the ready flag and the pipeline
//   and loads the default header bytes; the buffer is not cleared
//   configuration writes are taken at any edge with i_cfg_we high
// ----------------------------------------------------------------------------
module serial_frame_receiver_checksum #(
    parameter int FRAME_BYTES = 88
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    // input beats
    input  logic           i_valid,
    output logic           o_stall,
    input  sfr_pkg::t_item i_item,
    // result beats
    output logic           o_valid,
    input  logic           i_stall,
    output sfr_pkg::t_res  o_res
);

    sfr_pkg::t_cfg     r_cfg;
    sfr_pkg::t_step    step;
    sfr_pkg::t_mem_req mem_req;
    logic [7:0]        rd_data;

    // stage a: outcome of the accepted beat, read data comes from the buffer
    logic           r_a_vld;
    sfr_pkg::t_step r_a;
    // stage b: result register facing the receiver
    logic           r_b_vld;
    sfr_pkg::t_res  r_b;

    logic accept;
    logic b_take;
    logic a_move;

    assign b_take  = !r_b_vld || !i_stall;
    assign a_move  = r_a_vld && b_take;
    assign o_stall = r_a_vld && !b_take;
    assign accept  = i_valid && !o_stall;

    // configuration registers, writes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= sfr_pkg::HEADER_FIRST_RST;
            r_cfg.header_second <= sfr_pkg::HEADER_SECOND_RST;
            r_cfg.length_code   <= sfr_pkg::LENGTH_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfr_pkg::CFG_HEADER_FIRST:  r_cfg.header_first  <= i_cfg_data;
                sfr_pkg::CFG_HEADER_SECOND: r_cfg.header_second <= i_cfg_data;
                sfr_pkg::CFG_LENGTH_CODE:   r_cfg.length_code   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfr_deframer #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .o_step    (step),
        .o_mem_req (mem_req)
    );

    // read data only changes on an accepted read, so it stays with stage a
    sfr_frame_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_a_vld <= 1'b1;
            end else if (a_move) begin
                r_a_vld <= 1'b0;
            end
            if (a_move) begin
                r_b_vld <= 1'b1;
            end else if (b_take) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= step;
        end
        if (a_move) begin
            r_b.status        <= r_a.status;
            r_b.frame_ready   <= r_a.frame_ready;
            r_b.read_byte     <= r_a.rd_ok ? rd_data : 8'd0;
            r_b.byte_position <= r_a.byte_position;
        end
    end

    assign o_valid = r_b_vld;
    assign o_res   = r_b;

    // a frame good result always reports the ready flag set
    a_good_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == sfr_pkg::ST_GOOD) |-> o_res.frame_ready)
        else $error("frame good without ready flag");

    // a bad footer always reports the ready flag cleared
    a_footer_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == sfr_pkg::ST_FOOTER_BAD) |-> !o_res.frame_ready)
        else $error("footer error with ready flag set");

    // end-of-frame outcomes sit at the footer position
    a_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == sfr_pkg::ST_GOOD
                  || o_res.status == sfr_pkg::ST_CSUM_BAD
                  || o_res.status == sfr_pkg::ST_FOOTER_BAD))
        |-> (o_res.byte_position == 8'(FRAME_BYTES - 1)))
        else $error("frame end reported off the footer position");

    // a beat leaving stage a lands in the result register
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_move |=> r_b_vld)
        else $error("beat lost between stages");

endmodule

// ===== test/tb_serial_frame_receiver_checksum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver_checksum
// self-checking bench for the serial frame deframer with additive checksum
// ----------------------------------------------------------------------------
// a frame tracker mirrors the deframer state (phase, position, running sum,
// ready flag and frame store) and predicts one status beat per input beat
// stimulus is a short directed run followed by mostly well-formed frames with
// random payload, broken headers, line noise and buffer read-backs, repeated
// under several header settings; both handshakes see random gaps and stalls
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver_checksum;

    localparam int FRAME_BYTES     = 88;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int NUM_PHASES      = 6;
    localparam int DRAIN_CYCLES    = 6;     // extra wait after the last owed result
    localparam int WD_LIMIT        = 2000;  // cycles with no beat at all

    typedef enum int {
        FR_GOOD,
        FR_CSUM_BAD,
        FR_FOOTER_BAD
    } t_frame_kind;

    // ------------------------------------------------------------------------
    // frame tracker: predicted deframer state and the queue of status beats
    // still owed by the block
    // ------------------------------------------------------------------------
    class frame_tracker;
        logic [7:0]      hdr_first;
        logic [7:0]      hdr_second;
        logic [7:0]      len_code;
        sfr_pkg::t_phase phase;
        logic [7:0]      pos;
        logic [15:0]     sum;
        logic            ready;
        logic [7:0]      store [FRAME_BYTES];
        bit              written [FRAME_BYTES];
        sfr_pkg::t_res   owed [$];
        int              errors;

        function void init();
            hdr_first  = sfr_pkg::HEADER_FIRST_RST;
            hdr_second = sfr_pkg::HEADER_SECOND_RST;
            len_code   = sfr_pkg::LENGTH_CODE_RST;
            phase      = sfr_pkg::PH_HDR1;
            pos        = '0;
            sum        = '0;
            ready      = 1'b0;
            errors     = 0;
            foreach (written[k]) written[k] = 1'b0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // header byte the deframer is waiting for in the hunting phases
        function logic [7:0] wanted_header();
            case (phase)
                sfr_pkg::PH_HDR1: return hdr_first;
                sfr_pkg::PH_HDR2: return hdr_second;
                default:          return len_code;
            endcase
        endfunction

        function void put(logic [7:0] at, logic [7:0] b);
            if (at < FRAME_BYTES) begin
                store[at]   = b;
                written[at] = 1'b1;
            end
        endfunction

        function void hunt();
            phase = sfr_pkg::PH_HDR1;
            pos   = '0;
            sum   = '0;
        endfunction

        // accepted input beat: advance the state and owe one status beat
        function void note_item(sfr_pkg::t_item it);
            sfr_pkg::t_res r;
            logic [7:0]    b;
            logic [7:0]    here;
            logic [7:0]    lo;
            logic [7:0]    hi;
            r             = '0;
            r.status      = sfr_pkg::ST_HUNT;
            b             = it.rx_byte;
            here          = pos;
            if (it.mode) begin
                r.status    = sfr_pkg::ST_READ;
                r.read_byte = (it.read_index < FRAME_BYTES) ? store[it.read_index] : 8'h00;
            end else begin
                case (phase)
                    sfr_pkg::PH_HDR1, sfr_pkg::PH_HDR2, sfr_pkg::PH_LEN: begin
                        if (b == wanted_header()) begin
                            put(here, b);
                            if (phase == sfr_pkg::PH_LEN) sum = sum + {8'd0, b};
                            case (phase)
                                sfr_pkg::PH_HDR1: phase = sfr_pkg::PH_HDR2;
                                sfr_pkg::PH_HDR2: phase = sfr_pkg::PH_LEN;
                                default:          phase = sfr_pkg::PH_PAYLOAD;
                            endcase
                            pos             = here + 8'd1;
                            r.status        = sfr_pkg::ST_IN_FRAME;
                            r.byte_position = here;
                        end else begin
                            // dropped, and not tried again as a first header
                            phase = sfr_pkg::PH_HDR1;
                            pos   = '0;
                        end
                    end
                    sfr_pkg::PH_PAYLOAD: begin
                        put(here, b);
                        sum             = sum + {8'd0, b};
                        pos             = here + 8'd1;
                        if (pos == FRAME_BYTES - 3) phase = sfr_pkg::PH_CSUM;
                        r.status        = sfr_pkg::ST_IN_FRAME;
                        r.byte_position = here;
                    end
                    sfr_pkg::PH_CSUM: begin
                        put(here, b);
                        pos             = here + 8'd1;
                        if (pos == FRAME_BYTES - 1) phase = sfr_pkg::PH_FOOTER;
                        r.status        = sfr_pkg::ST_IN_FRAME;
                        r.byte_position = here;
                    end
                    sfr_pkg::PH_FOOTER: begin
                        put(here, b);
                        r.byte_position = here;
                        if (b == sfr_pkg::FOOTER_BYTE) begin
                            lo = store[here - 8'd2];
                            hi = store[here - 8'd1];
                            if ({hi, lo} == sum) begin
                                ready    = 1'b1;
                                r.status = sfr_pkg::ST_GOOD;
                            end else begin
                                // frame dropped, ready flag untouched
                                r.status = sfr_pkg::ST_CSUM_BAD;
                            end
                        end else begin
                            ready    = 1'b0;
                            r.status = sfr_pkg::ST_FOOTER_BAD;
                        end
                        hunt();
                    end
                    default: begin
                        hunt();
                        ready = 1'b0;
                    end
                endcase
            end
            r.frame_ready = ready;
            owed.push_back(r);
        endfunction

        // accepted result beat: compare against the oldest owed beat
        function void check_result(sfr_pkg::t_res got);
            sfr_pkg::t_res want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got status %0d pos %0d",
                         $time, got.status, got.byte_position);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.frame_ready !== want.frame_ready) begin
                $display("%0t: frame_ready mismatch, expected %0b, got %0b",
                         $time, want.frame_ready, got.frame_ready);
                errors++;
            end
            if (got.read_byte !== want.read_byte) begin
                $display("%0t: read_byte mismatch, expected %02h, got %02h",
                         $time, want.read_byte, got.read_byte);
                errors++;
            end
            if (got.byte_position !== want.byte_position) begin
                $display("%0t: byte_position mismatch, expected %0d, got %0d",
                         $time, want.byte_position, got.byte_position);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and instance
    // ------------------------------------------------------------------------
    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic [1:0]     i_cfg_idx;
    logic [7:0]     i_cfg_data;
    logic           i_valid;
    logic           o_stall;
    sfr_pkg::t_item i_item;
    logic           o_valid;
    logic           i_stall;
    sfr_pkg::t_res  o_res;

    frame_tracker trk;
    bit           tight;      // no sender gaps for the current segment
    int           counted;    // beats that count toward the phase budget
    int           quiet;      // watchdog: cycles without any beat

    serial_frame_receiver_checksum #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic sfr_pkg::t_item rx_beat(logic [7:0] b);
        sfr_pkg::t_item it;
        it.mode       = 1'b0;
        it.rx_byte    = b;
        it.read_index = 8'($urandom);   // ignored for a received byte
        return it;
    endfunction

    function automatic sfr_pkg::t_item read_beat(logic [7:0] idx);
        sfr_pkg::t_item it;
        it.mode       = 1'b1;
        it.rx_byte    = 8'($urandom);   // ignored for a read
        it.read_index = idx;
        return it;
    endfunction

    // read positions already written, or past the end of the store; never
    // a position that has not been written yet
    function automatic logic [7:0] pick_read_index();
        int k;
        case ($urandom_range(0, 5))
            0:       k = 0;
            1:       k = FRAME_BYTES - 1;
            default: k = $urandom_range(0, FRAME_BYTES - 1);
        endcase
        if (trk.written[k] && $urandom_range(0, 4) != 0) return 8'(k);
        return 8'($urandom_range(FRAME_BYTES, 255));
    endfunction

    // one input beat: present at the falling edge, hold until taken
    task automatic send_beat(input sfr_pkg::t_item it);
        int gap;
        @(negedge i_clk);
        i_item  = it;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        trk.note_item(it);
        gap = tight ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_item  = read_beat(8'($urandom));
        end
    endtask

    // received byte, with the odd read-back slipped in
    task automatic send_byte(input logic [7:0] b);
        send_beat(rx_beat(b));
        counted++;
        if ($urandom_range(0, 19) == 0) begin
            send_beat(read_beat(pick_read_index()));
            counted++;
        end
    endtask

    // bring the deframer back to header hunting before a new sequence
    task automatic resync();
        while (trk.phase != sfr_pkg::PH_HDR1) begin
            if (trk.phase == sfr_pkg::PH_HDR2 || trk.phase == sfr_pkg::PH_LEN)
                send_beat(rx_beat(trk.wanted_header() ^ 8'h01));
            else
                send_beat(rx_beat(8'($urandom)));
        end
    endtask

    task automatic send_frame(input t_frame_kind kind);
        logic [15:0] csum;
        logic [7:0]  b;
        logic [7:0]  foot;
        resync();
        send_byte(trk.hdr_first);
        send_byte(trk.hdr_second);
        send_byte(trk.len_code);
        csum = 16'(trk.len_code);
        for (int i = 3; i <= FRAME_BYTES - 4; i++) begin
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            csum = csum + {8'd0, b};
            send_byte(b);
        end
        if (kind == FR_CSUM_BAD) csum = csum ^ 16'($urandom_range(1, 65535));
        foot = sfr_pkg::FOOTER_BYTE;
        if (kind == FR_FOOTER_BAD) foot = sfr_pkg::FOOTER_BYTE ^ 8'($urandom_range(1, 255));
        // checksum goes out low byte first
        send_byte(csum[7:0]);
        send_byte(csum[15:8]);
        send_byte(foot);
    endtask

    // header that breaks off at the second sync byte or at the length code
    task automatic send_broken_header();
        resync();
        send_byte(trk.hdr_first);
        if ($urandom_range(0, 1) == 0) begin
            send_byte(trk.hdr_second ^ 8'($urandom_range(1, 255)));
        end else begin
            send_byte(trk.hdr_second);
            send_byte(trk.len_code ^ 8'($urandom_range(1, 255)));
        end
    endtask

    // drop valid and let every owed beat come back before touching registers
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (trk.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] h1, input logic [7:0] h2,
                                input logic [7:0] lc);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = sfr_pkg::CFG_HEADER_FIRST;
        i_cfg_data = h1;
        @(negedge i_clk);
        i_cfg_idx  = sfr_pkg::CFG_HEADER_SECOND;
        i_cfg_data = h2;
        @(negedge i_clk);
        i_cfg_idx  = sfr_pkg::CFG_LENGTH_CODE;
        i_cfg_data = lc;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        trk.hdr_first  = h1;
        trk.hdr_second = h2;
        trk.len_code   = lc;
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall, sampled at the rising edge
    // ------------------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                // a stretch that never stalls
                repeat ($urandom_range(20, 80)) begin
                    @(negedge i_clk);
                    i_stall = 1'b0;
                end
            end else begin
                repeat (pick_gap()) begin
                    @(negedge i_clk);
                    i_stall = 1'b1;
                end
                repeat ($urandom_range(1, 4)) begin
                    @(negedge i_clk);
                    i_stall = 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) trk.check_result(o_res);
    end

    // watchdog: a run that stops moving beats ends here
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else if (quiet >= WD_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WD_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        trk = new;
        trk.init();
        quiet      = 0;
        counted    = 0;
        tight      = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = sfr_pkg::CFG_HEADER_FIRST;
        i_cfg_data = 8'h00;
        i_valid    = 1'b0;
        i_item     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reads past the end, byte extremes while hunting
        send_beat(read_beat(8'hFF));
        send_beat(read_beat(8'(FRAME_BYTES)));
        send_beat(rx_beat(8'h00));
        send_beat(rx_beat(8'hFF));
        // bad second sync byte; the first sync byte repeated is not retried
        send_beat(rx_beat(sfr_pkg::HEADER_FIRST_RST));
        send_beat(rx_beat(sfr_pkg::HEADER_FIRST_RST));
        send_beat(rx_beat(sfr_pkg::HEADER_SECOND_RST));
        // bad length code
        send_beat(rx_beat(sfr_pkg::HEADER_FIRST_RST));
        send_beat(rx_beat(sfr_pkg::HEADER_SECOND_RST));
        send_beat(rx_beat(8'h00));
        // good frame sets ready, bad checksum keeps it, bad footer clears it
        send_frame(FR_GOOD);
        send_beat(read_beat(8'd0));
        send_beat(read_beat(8'(FRAME_BYTES - 1)));
        send_frame(FR_CSUM_BAD);
        send_frame(FR_FOOTER_BAD);
        send_frame(FR_GOOD);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // header settings: defaults, all zeros, all ones, defaults
            // written back, then random ones
            if (p > 0) begin
                drain();
                case (p)
                    1:       write_config(8'h00, 8'h00, 8'h00);
                    2:       write_config(8'hFF, 8'hFF, 8'hFF);
                    3:       write_config(sfr_pkg::HEADER_FIRST_RST,
                                          sfr_pkg::HEADER_SECOND_RST,
                                          sfr_pkg::LENGTH_CODE_RST);
                    default: write_config(8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                int r;
                tight = ($urandom_range(0, 3) == 0);
                r     = $urandom_range(0, 99);
                if (r < 40) begin
                    send_frame(FR_GOOD);
                end else if (r < 50) begin
                    send_frame(FR_CSUM_BAD);
                end else if (r < 60) begin
                    send_frame(FR_FOOTER_BAD);
                end else if (r < 75) begin
                    send_broken_header();
                end else if (r < 88) begin
                    // line noise while hunting; a byte that matches the first header starts a frame
                    repeat ($urandom_range(1, 8)) send_beat(rx_beat(8'($urandom)));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_beat(read_beat(pick_read_index()));
                        counted++;
                    end
                end
            end
        end

        drain();
        if (trk.errors == 0 && trk.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sfr_pkg.sv
rtl/sfr_frame_store.sv
rtl/sfr_deframer.sv
rtl/serial_frame_receiver_checksum.sv
test/tb_serial_frame_receiver_checksum.sv
